/* rtl/core/pulse_energy_meter_top_assert.svh */
// ---------------------------------------------------------------------------
// pulse energy meter assertion macros
// checks on the pulse energy meter, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef PULSE_ENERGY_METER_TOP_ASSERT_SVH
`define PULSE_ENERGY_METER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PEM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pulse energy meter check failed");

`define PEM_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pulse energy meter check failed");

`else

`define PEM_ASSERT_NEXT(name, clk, rst, ante, cons)

`define PEM_ASSERT_NOW(name, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/pem_pkg.sv */
// ---------------------------------------------------------------------------
// pem_pkg
// shared constants, register codes and types of the pulse energy meter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pem_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int DATA_BITS   = 32;
   localparam int ENERGY_BITS = 48;
   localparam int WIDE_BITS   = 64;
   localparam int ADDR_BITS   = 5;
   localparam int NOISE_LIMIT = 2;

   localparam logic [DATA_BITS-1:0] WINDOW_RESET = 32'd1000;

   typedef enum logic [2:0] {
      REG_WINDOW_TICKS      = 3'd0,
      REG_POWER_PER_PULSE   = 3'd1,
      REG_ENERGY_PER_PULSE  = 3'd2,
      REG_CURRENT_PER_PULSE = 3'd3,
      REG_VOLTAGE_PER_PULSE = 3'd4,
      REG_SELECT_PRESENT    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] window_ticks;
      logic [DATA_BITS-1:0] power_per_pulse;
      logic [DATA_BITS-1:0] energy_per_pulse;
      logic [DATA_BITS-1:0] current_per_pulse;
      logic [DATA_BITS-1:0] voltage_per_pulse;
      logic                 select_present;
   } cfg_type;

   typedef struct packed {
      logic cur_en;
      logic volt_en;
      logic upd_cur;
      logic upd_volt;
      logic select_level;
      logic settling;
   } ctl_type;

   function automatic logic [DATA_BITS-1:0] sat32(input logic [WIDE_BITS-1:0] v);
      logic [DATA_BITS-1:0] r;
      if (v[WIDE_BITS-1:DATA_BITS] != '0) begin
         r = '1;
      end else begin
         r = v[DATA_BITS-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/pem_csr.sv */
// ---------------------------------------------------------------------------
// pem_csr
// configuration registers behind the bus port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pem_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pem_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [pem_pkg::DATA_BITS-1:0]     pwdata,
   output logic [pem_pkg::DATA_BITS-1:0]     prdata,
   output logic                              pready,
   output pem_pkg::cfg_type                  cfg
);

   pem_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       reg_sel;
   logic             wr_en;

   assign reg_sel = paddr[pem_pkg::ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            pem_pkg::REG_WINDOW_TICKS:      cfg_in.window_ticks      = pwdata;
            pem_pkg::REG_POWER_PER_PULSE:   cfg_in.power_per_pulse   = pwdata;
            pem_pkg::REG_ENERGY_PER_PULSE:  cfg_in.energy_per_pulse  = pwdata;
            pem_pkg::REG_CURRENT_PER_PULSE: cfg_in.current_per_pulse = pwdata;
            pem_pkg::REG_VOLTAGE_PER_PULSE: cfg_in.voltage_per_pulse = pwdata;
            pem_pkg::REG_SELECT_PRESENT:    cfg_in.select_present    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         pem_pkg::REG_WINDOW_TICKS:      prdata = cfg_ff.window_ticks;
         pem_pkg::REG_POWER_PER_PULSE:   prdata = cfg_ff.power_per_pulse;
         pem_pkg::REG_ENERGY_PER_PULSE:  prdata = cfg_ff.energy_per_pulse;
         pem_pkg::REG_CURRENT_PER_PULSE: prdata = cfg_ff.current_per_pulse;
         pem_pkg::REG_VOLTAGE_PER_PULSE: prdata = cfg_ff.voltage_per_pulse;
         pem_pkg::REG_SELECT_PRESENT:
            prdata = {{(pem_pkg::DATA_BITS-1){1'b0}}, cfg_ff.select_present};
         default:                        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks      <= pem_pkg::WINDOW_RESET;
         cfg_ff.power_per_pulse   <= '0;
         cfg_ff.energy_per_pulse  <= '0;
         cfg_ff.current_per_pulse <= '0;
         cfg_ff.voltage_per_pulse <= '0;
         cfg_ff.select_present    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/pem_window.sv */
// ---------------------------------------------------------------------------
// pem_window
// pulse counting over a window, channel select sequencing and window snapshot
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pulse_energy_meter_top_assert.svh"

module pem_window #(
   parameter int COUNT_BITS = pem_pkg::COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pem_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_power_edge,
   input  logic                  req_channel_edge,
   input  logic                  s2_free,
   output logic                  s1_valid,
   output logic [COUNT_BITS-1:0] s1_pc,
   output logic [COUNT_BITS-1:0] s1_cc,
   output pem_pkg::ctl_type      s1_ctl
);

   localparam int DB = pem_pkg::DATA_BITS;

   logic [DB-1:0]         tick_ff, tick_in;
   logic [COUNT_BITS-1:0] pcnt_ff, pcnt_in;
   logic [COUNT_BITS-1:0] ccnt_ff, ccnt_in;
   logic                  on_volt_ff, on_volt_in;
   logic                  settle_ff, settle_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [COUNT_BITS-1:0] s1_pc_ff, s1_pc_in;
   logic [COUNT_BITS-1:0] s1_cc_ff, s1_cc_in;
   pem_pkg::ctl_type      s1_ctl_ff, s1_ctl_in;

   logic [DB-1:0]         win;
   logic [DB-1:0]         tick_inc;
   logic [COUNT_BITS-1:0] pcnt_bump;
   logic [COUNT_BITS-1:0] ccnt_bump;
   logic                  accept;
   logic                  close;
   logic                  s1_adv;
   logic                  cur_en;
   logic                  volt_en;

   assign req_stall = s1_valid_ff && !s2_free;
   assign accept    = req_valid && !req_stall;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign s1_valid  = s1_valid_ff;
   assign s1_pc     = s1_pc_ff;
   assign s1_cc     = s1_cc_ff;
   assign s1_ctl    = s1_ctl_ff;

   assign win     = (cfg.window_ticks == '0) ? DB'(1) : cfg.window_ticks;
   assign cur_en  = (cfg.current_per_pulse != '0);
   assign volt_en = cfg.select_present && (cfg.voltage_per_pulse != '0);

   always_comb begin
      pcnt_bump = pcnt_ff;
      if (req_power_edge && (pcnt_ff != '1)) begin
         pcnt_bump = pcnt_ff + COUNT_BITS'(1);
      end
      ccnt_bump = ccnt_ff;
      if (req_channel_edge && (ccnt_ff != '1)) begin
         ccnt_bump = ccnt_ff + COUNT_BITS'(1);
      end
      tick_inc = (tick_ff == '1) ? tick_ff : tick_ff + DB'(1);
      close    = accept && (tick_inc >= win);
   end

   always_comb begin
      tick_in     = tick_ff;
      pcnt_in     = pcnt_ff;
      ccnt_in     = ccnt_ff;
      on_volt_in  = on_volt_ff;
      settle_in   = settle_ff;
      s1_pc_in    = s1_pc_ff;
      s1_cc_in    = s1_cc_ff;
      s1_ctl_in   = s1_ctl_ff;
      s1_valid_in = s1_adv ? 1'b0 : s1_valid_ff;
      if (close) begin
         tick_in = '0;
         pcnt_in = '0;
         ccnt_in = '0;
         // counts below the noise limit read as zero
         s1_pc_in = (pcnt_bump < COUNT_BITS'(pem_pkg::NOISE_LIMIT)) ? '0 : pcnt_bump;
         s1_cc_in = (ccnt_bump < COUNT_BITS'(pem_pkg::NOISE_LIMIT)) ? '0 : ccnt_bump;
         if (volt_en && cur_en) begin
            if (settle_ff) begin
               settle_in = 1'b0;
            end else begin
               on_volt_in = !on_volt_ff;
               settle_in  = 1'b1;
            end
         end
         s1_ctl_in.cur_en       = cur_en;
         s1_ctl_in.volt_en      = volt_en;
         s1_ctl_in.upd_cur      = !settle_ff && !on_volt_ff && cur_en;
         s1_ctl_in.upd_volt     = !settle_ff && on_volt_ff && (cfg.voltage_per_pulse != '0);
         s1_ctl_in.select_level = on_volt_in;
         s1_ctl_in.settling     = settle_in;
         s1_valid_in            = 1'b1;
      end else if (accept) begin
         tick_in = tick_inc;
         pcnt_in = pcnt_bump;
         ccnt_in = ccnt_bump;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         pcnt_ff     <= '0;
         ccnt_ff     <= '0;
         on_volt_ff  <= 1'b0;
         settle_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         tick_ff     <= tick_in;
         pcnt_ff     <= pcnt_in;
         ccnt_ff     <= ccnt_in;
         on_volt_ff  <= on_volt_in;
         settle_ff   <= settle_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pc_ff  <= s1_pc_in;
      s1_cc_ff  <= s1_cc_in;
      s1_ctl_ff <= s1_ctl_in;
   end

   `PEM_ASSERT_NEXT(a_close_clears, clock, reset, close, (tick_ff == '0) && (pcnt_ff == '0) && (ccnt_ff == '0))
   `PEM_ASSERT_NOW(a_settle_follows_switch, clock, reset, $rose(settle_ff), on_volt_ff != $past(on_volt_ff))
   `PEM_ASSERT_NOW(a_snapshot_room, clock, reset, close, !s1_valid_ff || s1_adv)

endmodule

/* rtl/core/pem_scale.sv */
// ---------------------------------------------------------------------------
// pem_scale
// multiplies the window counts by the power, energy and channel coefficients
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pem_scale #(
   parameter int COUNT_BITS = pem_pkg::COUNT_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pem_pkg::cfg_type                        cfg,
   input  logic                                    s1_valid,
   input  logic [COUNT_BITS-1:0]                   s1_pc,
   input  logic [COUNT_BITS-1:0]                   s1_cc,
   input  pem_pkg::ctl_type                        s1_ctl,
   input  logic                                    out_free,
   output logic                                    s2_free,
   output logic                                    s2_valid,
   output logic [COUNT_BITS+pem_pkg::DATA_BITS-1:0] s2_pprod,
   output logic [COUNT_BITS+pem_pkg::DATA_BITS-1:0] s2_eprod,
   output logic [COUNT_BITS+pem_pkg::DATA_BITS-1:0] s2_cprod,
   output pem_pkg::ctl_type                        s2_ctl
);

   localparam int PB = COUNT_BITS + pem_pkg::DATA_BITS;

   logic                         s2_valid_ff, s2_valid_in;
   logic [PB-1:0]                pprod_ff, pprod_in;
   logic [PB-1:0]                eprod_ff, eprod_in;
   logic [PB-1:0]                cprod_ff, cprod_in;
   pem_pkg::ctl_type             ctl_ff, ctl_in;
   logic [pem_pkg::DATA_BITS-1:0] chan_coef;
   logic                         load;

   assign s2_free   = !s2_valid_ff || out_free;
   assign load      = s1_valid && s2_free;
   assign chan_coef = s1_ctl.upd_volt ? cfg.voltage_per_pulse : cfg.current_per_pulse;

   always_comb begin
      pprod_in    = pprod_ff;
      eprod_in    = eprod_ff;
      cprod_in    = cprod_ff;
      ctl_in      = ctl_ff;
      s2_valid_in = (s2_valid_ff && !out_free) ? 1'b1 : 1'b0;
      if (load) begin
         pprod_in    = PB'(s1_pc) * PB'(cfg.power_per_pulse);
         eprod_in    = PB'(s1_pc) * PB'(cfg.energy_per_pulse);
         cprod_in    = PB'(s1_cc) * PB'(chan_coef);
         ctl_in      = s1_ctl;
         s2_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pprod_ff <= pprod_in;
      eprod_ff <= eprod_in;
      cprod_ff <= cprod_in;
      ctl_ff   <= ctl_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2_pprod = pprod_ff;
   assign s2_eprod = eprod_ff;
   assign s2_cprod = cprod_ff;
   assign s2_ctl   = ctl_ff;

endmodule

/* rtl/core/pem_result.sv */
// ---------------------------------------------------------------------------
// pem_result
// saturation, energy accumulation, readings and the result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pulse_energy_meter_top_assert.svh"

module pem_result #(
   parameter int COUNT_BITS = pem_pkg::COUNT_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     s2_valid,
   input  logic [COUNT_BITS+pem_pkg::DATA_BITS-1:0] s2_pprod,
   input  logic [COUNT_BITS+pem_pkg::DATA_BITS-1:0] s2_eprod,
   input  logic [COUNT_BITS+pem_pkg::DATA_BITS-1:0] s2_cprod,
   input  pem_pkg::ctl_type                         s2_ctl,
   output logic                                     out_free,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [pem_pkg::DATA_BITS-1:0]            rsp_power_value,
   output logic [pem_pkg::ENERGY_BITS-1:0]          rsp_energy_value,
   output logic [pem_pkg::DATA_BITS-1:0]            rsp_current_value,
   output logic [pem_pkg::DATA_BITS-1:0]            rsp_voltage_value,
   output logic                                     rsp_current_valid,
   output logic                                     rsp_voltage_valid,
   output logic                                     rsp_select_level,
   output logic                                     rsp_settling
);

   localparam int WB = pem_pkg::WIDE_BITS;
   localparam int EB = pem_pkg::ENERGY_BITS;
   localparam int DB = pem_pkg::DATA_BITS;

   logic          valid_ff, valid_in;
   logic [DB-1:0] power_ff, power_in;
   logic [EB-1:0] energy_ff, energy_in;
   logic [DB-1:0] current_ff, current_in;
   logic [DB-1:0] voltage_ff, voltage_in;
   pem_pkg::ctl_type ctl_ff, ctl_in;

   logic          load;
   logic [WB-1:0] e_wide;
   logic [EB:0]   e_sum;
   logic [DB-1:0] chan_sat;

   assign out_free = !valid_ff || !rsp_stall;
   assign load     = s2_valid && out_free;
   assign e_wide   = WB'(s2_eprod);
   assign e_sum    = {1'b0, energy_ff} + {1'b0, e_wide[EB-1:0]};
   assign chan_sat = pem_pkg::sat32(WB'(s2_cprod));

   always_comb begin
      power_in   = power_ff;
      energy_in  = energy_ff;
      current_in = current_ff;
      voltage_in = voltage_ff;
      ctl_in     = ctl_ff;
      valid_in   = out_free ? 1'b0 : valid_ff;
      if (load) begin
         power_in = pem_pkg::sat32(WB'(s2_pprod));
         if ((e_wide[WB-1:EB] != '0) || e_sum[EB]) begin
            energy_in = '1;
         end else begin
            energy_in = e_sum[EB-1:0];
         end
         if (s2_ctl.upd_cur) begin
            current_in = chan_sat;
         end
         if (s2_ctl.upd_volt) begin
            voltage_in = chan_sat;
         end
         ctl_in   = s2_ctl;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         power_ff   <= '0;
         energy_ff  <= '0;
         current_ff <= '0;
         voltage_ff <= '0;
         ctl_ff     <= '0;
      end else begin
         valid_ff   <= valid_in;
         power_ff   <= power_in;
         energy_ff  <= energy_in;
         current_ff <= current_in;
         voltage_ff <= voltage_in;
         ctl_ff     <= ctl_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_power_value   = power_ff;
   assign rsp_energy_value  = energy_ff;
   assign rsp_current_value = current_ff;
   assign rsp_voltage_value = voltage_ff;
   assign rsp_current_valid = ctl_ff.cur_en;
   assign rsp_voltage_valid = ctl_ff.volt_en;
   assign rsp_select_level  = ctl_ff.select_level;
   assign rsp_settling      = ctl_ff.settling;

   `PEM_ASSERT_NEXT(a_energy_never_drops, clock, reset, 1'b1, energy_ff >= $past(energy_ff))
   `PEM_ASSERT_NOW(a_one_reading_updated, clock, reset, s2_valid, !(s2_ctl.upd_cur && s2_ctl.upd_volt))

endmodule

/* rtl/core/pulse_energy_meter_top.sv */
// ---------------------------------------------------------------------------
// pulse_energy_meter_top
// pulse-output energy meter with current/voltage channel select
// ---------------------------------------------------------------------------
// Each request beat is one tick of edge flags for the power and the
// current/voltage pulse lines; one beat is taken every clock cycle unless
// req_stall is high. Pulses are counted over window_ticks ticks (zero acts as
// one); only the beat closing a window yields a response beat, through a count
// stage, a multiply stage and the result register. Power, energy and readings
// saturate; the select output alternates between current and voltage with a
// settle window after each switch once both are calibrated. The user must write
// registers only while no window result is pending; this is not enforced.
`timescale 1ns / 1ps

module pulse_energy_meter_top #(
   parameter int COUNT_BITS = pem_pkg::COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pem_pkg::ADDR_BITS-1:0]      paddr,
   input  logic [pem_pkg::DATA_BITS-1:0]      pwdata,
   output logic [pem_pkg::DATA_BITS-1:0]      prdata,
   output logic                               pready,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_power_edge,
   input  logic                               req_channel_edge,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pem_pkg::DATA_BITS-1:0]      rsp_power_value,
   output logic [pem_pkg::ENERGY_BITS-1:0]    rsp_energy_value,
   output logic [pem_pkg::DATA_BITS-1:0]      rsp_current_value,
   output logic [pem_pkg::DATA_BITS-1:0]      rsp_voltage_value,
   output logic                               rsp_current_valid,
   output logic                               rsp_voltage_valid,
   output logic                               rsp_select_level,
   output logic                               rsp_settling
);

   localparam int PB = COUNT_BITS + pem_pkg::DATA_BITS;

   pem_pkg::cfg_type      cfg;
   logic                  s1_valid;
   logic [COUNT_BITS-1:0] s1_pc;
   logic [COUNT_BITS-1:0] s1_cc;
   pem_pkg::ctl_type      s1_ctl;
   logic                  s2_free;
   logic                  s2_valid;
   logic [PB-1:0]         s2_pprod;
   logic [PB-1:0]         s2_eprod;
   logic [PB-1:0]         s2_cprod;
   pem_pkg::ctl_type      s2_ctl;
   logic                  out_free;

   pem_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pem_window #(.COUNT_BITS(COUNT_BITS)) u_window (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_power_edge   (req_power_edge),
      .req_channel_edge (req_channel_edge),
      .s2_free          (s2_free),
      .s1_valid         (s1_valid),
      .s1_pc            (s1_pc),
      .s1_cc            (s1_cc),
      .s1_ctl           (s1_ctl)
   );

   pem_scale #(.COUNT_BITS(COUNT_BITS)) u_scale (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1_valid (s1_valid),
      .s1_pc    (s1_pc),
      .s1_cc    (s1_cc),
      .s1_ctl   (s1_ctl),
      .out_free (out_free),
      .s2_free  (s2_free),
      .s2_valid (s2_valid),
      .s2_pprod (s2_pprod),
      .s2_eprod (s2_eprod),
      .s2_cprod (s2_cprod),
      .s2_ctl   (s2_ctl)
   );

   pem_result #(.COUNT_BITS(COUNT_BITS)) u_result (
      .clock             (clock),
      .reset             (reset),
      .s2_valid          (s2_valid),
      .s2_pprod          (s2_pprod),
      .s2_eprod          (s2_eprod),
      .s2_cprod          (s2_cprod),
      .s2_ctl            (s2_ctl),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_power_value   (rsp_power_value),
      .rsp_energy_value  (rsp_energy_value),
      .rsp_current_value (rsp_current_value),
      .rsp_voltage_value (rsp_voltage_value),
      .rsp_current_valid (rsp_current_valid),
      .rsp_voltage_valid (rsp_voltage_valid),
      .rsp_select_level  (rsp_select_level),
      .rsp_settling      (rsp_settling)
   );

endmodule

/* tb/pulse_energy_meter_top_tb.sv */
// ---------------------------------------------------------------------------
// pulse_energy_meter_top_tb
// ---------------------------------------------------------------------------
// Self-checking bench for the pulse energy meter. Tick beats carrying power
// and channel edge flags go in while an in-bench predictor of the window
// counters, saturating products, energy total and current/voltage select
// tracks every accepted beat and queues the window reading it should close.
// Each response beat is compared field by field with the oldest queued
// reading. A directed table covers the field and coefficient extremes, product
// saturation, a shortened window and the channel alternation; random phases
// with random register settings, edge densities and idle bursts on both sides
// follow, one of them with a long response hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_energy_meter_top_tb;

   localparam int DATA_BITS   = pem_pkg::DATA_BITS;
   localparam int ENERGY_BITS = pem_pkg::ENERGY_BITS;
   localparam int COUNT_BITS  = pem_pkg::COUNT_BITS;
   localparam int ADDR_BITS   = pem_pkg::ADDR_BITS;

   localparam int unsigned RANDOM_TICKS   = 600;
   localparam int unsigned QUIET_TICKS    = 150;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 5000;

   localparam logic [DATA_BITS-1:0]   WORD_FULL   = '1;
   localparam logic [ENERGY_BITS-1:0] ENERGY_FULL = '1;

   typedef struct packed {
      logic [DATA_BITS-1:0]   power;
      logic [ENERGY_BITS-1:0] energy;
      logic [DATA_BITS-1:0]   current;
      logic [DATA_BITS-1:0]   voltage;
      logic                   current_valid;
      logic                   voltage_valid;
      logic                   select_level;
      logic                   settling;
   } meter_reading_type;

   typedef enum {ROW_CSR, ROW_TICKS} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      pem_pkg::reg_index_type reg_sel;
      logic [DATA_BITS-1:0]   value;
      logic                   pe;
      logic                   ce;
      int unsigned            reps;
      bit                     typed;
      meter_reading_type      want;
   } stim_row_type;

   localparam meter_reading_type NO_PULSES = '0;
   localparam meter_reading_type PRODUCTS_FULL =
      {32'hFFFF_FFFF, 48'h3_FFFF_FFFC, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [ADDR_BITS-1:0]   paddr = '0;
   logic [DATA_BITS-1:0]   pwdata = '0;
   logic [DATA_BITS-1:0]   prdata;
   logic                   pready;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_power_edge = 1'b0;
   logic                   req_channel_edge = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [DATA_BITS-1:0]   rsp_power_value;
   logic [ENERGY_BITS-1:0] rsp_energy_value;
   logic [DATA_BITS-1:0]   rsp_current_value;
   logic [DATA_BITS-1:0]   rsp_voltage_value;
   logic                   rsp_current_valid;
   logic                   rsp_voltage_valid;
   logic                   rsp_select_level;
   logic                   rsp_settling;

   // predictor configuration
   logic [DATA_BITS-1:0] cfg_window = pem_pkg::WINDOW_RESET;
   logic [DATA_BITS-1:0] cfg_power = '0;
   logic [DATA_BITS-1:0] cfg_energy = '0;
   logic [DATA_BITS-1:0] cfg_current = '0;
   logic [DATA_BITS-1:0] cfg_voltage = '0;
   logic                 cfg_select = 1'b0;

   // predictor state
   logic [DATA_BITS-1:0]   elapsed_ticks = '0;
   logic [COUNT_BITS-1:0]  power_pulses = '0;
   logic [COUNT_BITS-1:0]  channel_pulses = '0;
   logic [DATA_BITS-1:0]   power_now = '0;
   logic [ENERGY_BITS-1:0] energy_total = '0;
   logic [DATA_BITS-1:0]   current_now = '0;
   logic [DATA_BITS-1:0]   voltage_now = '0;
   logic                   on_voltage = 1'b0;
   logic                   settle_next = 1'b0;

   meter_reading_type expected_readings[$];
   stim_row_type      stim_rows[$];

   int unsigned fail_count = 0;
   int unsigned ticks_sent = 0;
   int unsigned random_ticks = 0;
   int unsigned readings_checked = 0;
   int unsigned csr_writes = 0;
   bit          quiet = 1'b0;
   bit          hold_request = 1'b0;

   pulse_energy_meter_top dut (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_power_edge    (req_power_edge),
      .req_channel_edge  (req_channel_edge),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_power_value   (rsp_power_value),
      .rsp_energy_value  (rsp_energy_value),
      .rsp_current_value (rsp_current_value),
      .rsp_voltage_value (rsp_voltage_value),
      .rsp_current_valid (rsp_current_valid),
      .rsp_voltage_valid (rsp_voltage_valid),
      .rsp_select_level  (rsp_select_level),
      .rsp_settling      (rsp_settling)
   );

   always #5 clock = ~clock;

   function automatic logic [DATA_BITS-1:0] pulse_product(
         input logic [COUNT_BITS-1:0] count,
         input logic [DATA_BITS-1:0]  coeff);
      logic [63:0] p;
      p = 64'(count) * 64'(coeff);
      return (p > 64'(WORD_FULL)) ? WORD_FULL : p[DATA_BITS-1:0];
   endfunction

   // advances the meter by one tick, returns 1 when the tick closes a window
   function automatic bit meter_tick(input logic pe, input logic ce,
                                     output meter_reading_type r);
      logic [DATA_BITS-1:0]  win;
      logic [COUNT_BITS-1:0] pc;
      logic [COUNT_BITS-1:0] cc;
      logic [63:0]           add;
      logic [63:0]           room;
      logic                  volt_en;
      logic                  cur_en;
      r = '0;
      win = (cfg_window == '0) ? 32'd1 : cfg_window;
      if (pe && power_pulses != '1) power_pulses++;
      if (ce && channel_pulses != '1) channel_pulses++;
      if (elapsed_ticks != '1) elapsed_ticks++;
      if (elapsed_ticks < win) return 1'b0;

      // fewer than two pulses is noise
      pc = (power_pulses < pem_pkg::NOISE_LIMIT) ? '0 : power_pulses;
      cc = (channel_pulses < pem_pkg::NOISE_LIMIT) ? '0 : channel_pulses;

      power_now = pulse_product(pc, cfg_power);
      add = 64'(pc) * 64'(cfg_energy);
      room = 64'(ENERGY_FULL - energy_total);
      energy_total = (add > room) ? ENERGY_FULL : energy_total + add[ENERGY_BITS-1:0];

      volt_en = cfg_select && cfg_voltage != '0;
      cur_en = cfg_current != '0;
      if (!settle_next) begin
         if (on_voltage) begin
            if (cfg_voltage != '0) voltage_now = pulse_product(cc, cfg_voltage);
         end else if (cur_en) begin
            current_now = pulse_product(cc, cfg_current);
         end
      end
      if (volt_en && cur_en) begin
         if (settle_next) begin
            settle_next = 1'b0;
         end else begin
            on_voltage = ~on_voltage;
            settle_next = 1'b1;
         end
      end

      elapsed_ticks = '0;
      power_pulses = '0;
      channel_pulses = '0;
      r = {power_now, energy_total, current_now, voltage_now, cur_en, volt_en,
           on_voltage, settle_next};
      return 1'b1;
   endfunction

   function automatic logic [DATA_BITS-1:0] pick_coeff();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return WORD_FULL;
         2: return 32'd1;
         3: return 32'($urandom_range(1, 255)) << 16;
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned pick_density();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 25;
         2: return 50;
         3: return 85;
         default: return 100;
      endcase
   endfunction

   function automatic stim_row_type csr_row(input pem_pkg::reg_index_type idx,
                                            input logic [DATA_BITS-1:0] value);
      stim_row_type r;
      r.kind = ROW_CSR;
      r.reg_sel = idx;
      r.value = value;
      r.pe = 1'b0;
      r.ce = 1'b0;
      r.reps = 0;
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic stim_row_type tick_row(input logic pe, input logic ce,
                                             input int unsigned reps, input bit typed,
                                             input meter_reading_type want);
      stim_row_type r;
      r.kind = ROW_TICKS;
      r.reg_sel = pem_pkg::REG_WINDOW_TICKS;
      r.value = '0;
      r.pe = pe;
      r.ce = ce;
      r.reps = reps;
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic csr_write(input pem_pkg::reg_index_type idx,
                            input logic [DATA_BITS-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do begin
         @(posedge clock);
      end while (pready !== 1'b1);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      case (idx)
         pem_pkg::REG_WINDOW_TICKS:      cfg_window = value;
         pem_pkg::REG_POWER_PER_PULSE:   cfg_power = value;
         pem_pkg::REG_ENERGY_PER_PULSE:  cfg_energy = value;
         pem_pkg::REG_CURRENT_PER_PULSE: cfg_current = value;
         pem_pkg::REG_VOLTAGE_PER_PULSE: cfg_voltage = value;
         pem_pkg::REG_SELECT_PRESENT:    cfg_select = value[0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic send_tick(input logic pe, input logic ce, input bit typed,
                            input meter_reading_type want);
      meter_reading_type predicted;
      bit                produced;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_power_edge = pe;
      req_channel_edge = ce;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      produced = meter_tick(pe, ce, predicted);
      if (typed) expected_readings.push_back(want);
      else if (produced) expected_readings.push_back(predicted);
      ticks_sent++;
   endtask

   // stop sending and let every pending window reading come out
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic walk_rows();
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            drain_results();
            csr_write(stim_rows[i].reg_sel, stim_rows[i].value);
         end else begin
            for (int unsigned k = 0; k < stim_rows[i].reps; k++) begin
               send_tick(stim_rows[i].pe, stim_rows[i].ce,
                         stim_rows[i].typed && k == stim_rows[i].reps - 1, stim_rows[i].want);
            end
         end
      end
   endtask

   // response side: random stall bursts, one long hold-off on request
   initial begin : response_side
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_check
      meter_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $error("response beat with no window reading expected");
            fail_count++;
         end else begin
            want = expected_readings.pop_front();
            check_field("power_value", 64'(want.power), 64'(rsp_power_value));
            check_field("energy_value", 64'(want.energy), 64'(rsp_energy_value));
            check_field("current_value", 64'(want.current), 64'(rsp_current_value));
            check_field("voltage_value", 64'(want.voltage), 64'(rsp_voltage_value));
            check_field("current_valid", 64'(want.current_valid), 64'(rsp_current_valid));
            check_field("voltage_valid", 64'(want.voltage_valid), 64'(rsp_voltage_valid));
            check_field("select_level", 64'(want.select_level), 64'(rsp_select_level));
            check_field("settling", 64'(want.settling), 64'(rsp_settling));
            readings_checked++;
         end
      end
   end

   initial begin : watchdog
      int unsigned stuck;
      stuck = 0;
      while (stuck < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck = 0;
         else stuck++;
      end
      $display("pulse_energy_meter_top_tb failed");
      $finish;
   end

   initial begin : main_flow
      int unsigned n;
      int unsigned pe_density;
      int unsigned ce_density;
      bit          first_phase;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero window acts as one tick, single pulses are noise
      stim_rows.push_back(csr_row(pem_pkg::REG_WINDOW_TICKS, '0));
      stim_rows.push_back(tick_row(1'b1, 1'b1, 1, 1'b1, NO_PULSES));
      stim_rows.push_back(tick_row(1'b1, 1'b0, 1, 1'b1, NO_PULSES));
      stim_rows.push_back(tick_row(1'b0, 1'b1, 1, 1'b1, NO_PULSES));
      // short window with unit coefficients
      stim_rows.push_back(csr_row(pem_pkg::REG_CURRENT_PER_PULSE, 32'd1));
      stim_rows.push_back(csr_row(pem_pkg::REG_POWER_PER_PULSE, 32'd1));
      stim_rows.push_back(csr_row(pem_pkg::REG_WINDOW_TICKS, 32'd4));
      stim_rows.push_back(tick_row(1'b1, 1'b1, 4, 1'b0, NO_PULSES));
      // longest window, then cut short below the elapsed ticks
      stim_rows.push_back(csr_row(pem_pkg::REG_WINDOW_TICKS, WORD_FULL));
      stim_rows.push_back(csr_row(pem_pkg::REG_POWER_PER_PULSE, WORD_FULL));
      stim_rows.push_back(csr_row(pem_pkg::REG_CURRENT_PER_PULSE, WORD_FULL));
      stim_rows.push_back(csr_row(pem_pkg::REG_ENERGY_PER_PULSE, WORD_FULL));
      stim_rows.push_back(tick_row(1'b1, 1'b0, 3, 1'b0, NO_PULSES));
      stim_rows.push_back(csr_row(pem_pkg::REG_WINDOW_TICKS, 32'd2));
      stim_rows.push_back(tick_row(1'b1, 1'b1, 1, 1'b1, PRODUCTS_FULL));
      // both channels calibrated, select alternates with settle windows
      stim_rows.push_back(csr_row(pem_pkg::REG_ENERGY_PER_PULSE, 32'd1));
      stim_rows.push_back(csr_row(pem_pkg::REG_POWER_PER_PULSE, 32'd7));
      stim_rows.push_back(csr_row(pem_pkg::REG_CURRENT_PER_PULSE, 32'd5));
      stim_rows.push_back(csr_row(pem_pkg::REG_VOLTAGE_PER_PULSE, 32'd3));
      stim_rows.push_back(csr_row(pem_pkg::REG_SELECT_PRESENT, 32'd1));
      stim_rows.push_back(csr_row(pem_pkg::REG_WINDOW_TICKS, 32'd3));
      stim_rows.push_back(tick_row(1'b1, 1'b1, 12, 1'b0, NO_PULSES));
      stim_rows.push_back(tick_row(1'b0, 1'b1, 3, 1'b0, NO_PULSES));
      stim_rows.push_back(tick_row(1'b1, 1'b0, 3, 1'b0, NO_PULSES));
      // selected channel loses its calibration
      stim_rows.push_back(csr_row(pem_pkg::REG_VOLTAGE_PER_PULSE, '0));
      stim_rows.push_back(tick_row(1'b1, 1'b1, 6, 1'b0, NO_PULSES));
      stim_rows.push_back(csr_row(pem_pkg::REG_SELECT_PRESENT, '0));
      stim_rows.push_back(csr_row(pem_pkg::REG_VOLTAGE_PER_PULSE, 32'd9));
      stim_rows.push_back(tick_row(1'b1, 1'b1, 6, 1'b0, NO_PULSES));
      stim_rows.push_back(tick_row(1'b0, 1'b0, 3, 1'b0, NO_PULSES));
      walk_rows();

      first_phase = 1'b1;
      while (random_ticks < RANDOM_TICKS) begin
         drain_results();
         quiet = (random_ticks >= RANDOM_TICKS - QUIET_TICKS);
         if (first_phase) begin
            // every beat closes a window while the response side holds off
            csr_write(pem_pkg::REG_WINDOW_TICKS, '0);
            hold_request = 1'b1;
            n = 60;
            pe_density = 70;
            ce_density = 70;
            first_phase = 1'b0;
         end else begin
            case ($urandom_range(0, 7))
               0: csr_write(pem_pkg::REG_WINDOW_TICKS, '0);
               1: csr_write(pem_pkg::REG_WINDOW_TICKS, 32'd1);
               7: csr_write(pem_pkg::REG_WINDOW_TICKS, $urandom_range(8, 40));
               default: csr_write(pem_pkg::REG_WINDOW_TICKS, $urandom_range(2, 6));
            endcase
            if ($urandom_range(0, 1)) csr_write(pem_pkg::REG_POWER_PER_PULSE, pick_coeff());
            if ($urandom_range(0, 1)) csr_write(pem_pkg::REG_ENERGY_PER_PULSE, pick_coeff());
            if ($urandom_range(0, 1)) csr_write(pem_pkg::REG_CURRENT_PER_PULSE, pick_coeff());
            if ($urandom_range(0, 1)) csr_write(pem_pkg::REG_VOLTAGE_PER_PULSE, pick_coeff());
            if ($urandom_range(0, 1)) begin
               csr_write(pem_pkg::REG_SELECT_PRESENT, $urandom_range(0, 1));
            end
            n = $urandom_range(20, 60);
            pe_density = pick_density();
            ce_density = pick_density();
         end
         repeat (n) begin
            send_tick($urandom_range(0, 99) < pe_density, $urandom_range(0, 99) < ce_density,
                      1'b0, NO_PULSES);
            random_ticks++;
         end
      end

      quiet = 1'b1;
      drain_results();

      $display("%0d tick beats (%0d random) gave %0d window readings, all checked",
               ticks_sent, random_ticks, readings_checked);
      $display("%0d register writes, windows from 0 to 2^32-1 ticks", csr_writes);
      if (fail_count == 0) begin
         $display("pulse_energy_meter_top_tb passed");
      end else begin
         $display("pulse_energy_meter_top_tb failed");
      end
      $finish;
   end

endmodule
